[hw/rtl/clat_pkg.sv]
// Shared types, byte codes and defaults for the command line assembler tokenizer.
package clat_pkg;

    // Default sizing
    localparam int LINE_LEN_DEF   = 64;
    localparam int MAX_TOKENS_DEF = 10;

    // Received byte codes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    // Line end cause reported with every request
    typedef enum logic [1:0] {
        CAUSE_EOL    = 2'd0,
        CAUSE_CANCEL = 2'd1,
        CAUSE_FULL   = 2'd2
    } t_cause;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_FIN
    } t_state;

    // Token separator test
    function automatic logic blank_char(input logic [7:0] c);
        return c inside {CH_SP, CH_NUL, CH_TAB, CH_CR, CH_LF};
    endfunction

endpackage

[hw/rtl/clat_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module clat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read; read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/command_line_assembler_tokenizer_unit.sv]
// Top level: serial command line assembler with token scanner.
//
// Input channel: one received byte per request (i_in_valid / o_in_stall /
// i_rx_byte). Ordinary bytes are stored in the line RAM, backspace drops the
// last stored byte, ETX cancels the line, CR or LF ends it, and a byte that
// arrives when LINE_LEN-1 bytes are stored is dropped and ends the line.
// Output channel: one request per token (o_out_valid / i_out_stall and the
// token fields), or one request with o_token_valid low when the line holds no
// token; o_last_token marks the final request of a line.
// A line end starts a walk of the line RAM from offset 0: each stored byte is
// read (read issue in S_RD), then classified in S_CHK through the blank/NUL
// compare, and the walk closes through S_RD and S_FIN. The single RAM read
// port and its registered read set this read-then-classify order. o_in_stall
// is high for the whole walk. The output register lets the next byte be
// accepted while the last request still waits; when the receiver stalls, the
// walk holds at the next token boundary until the output register frees.
// Reset clears the write position, the sequencer and the output valid; the
// line RAM is not cleared, since only bytes written for the current line are
// ever read.
module command_line_assembler_tokenizer_unit #(
    parameter int LINE_LEN   = clat_pkg::LINE_LEN_DEF,
    parameter int MAX_TOKENS = clat_pkg::MAX_TOKENS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_token_valid,
    output logic [3:0] o_token_index,
    output logic [5:0] o_token_start,
    output logic [5:0] o_token_length,
    output logic [5:0] o_line_length,
    output logic [1:0] o_end_cause,
    output logic       o_last_token
);

    localparam int AW = $clog2(LINE_LEN);
    localparam int CW = $clog2(MAX_TOKENS + 1);

    clat_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_len, n_len;
    clat_pkg::t_cause r_cause, n_cause;
    logic [AW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_in_tok, n_in_tok;
    logic             r_prev_nul, n_prev_nul;
    logic [AW-1:0]    r_pstart, n_pstart;
    logic [AW-1:0]    r_plen, n_plen;

    logic             r_ovalid;
    logic             r_tvalid;
    logic [3:0]       r_tindex;
    logic [5:0]       r_tstart;
    logic [5:0]       r_tlen;
    logic [5:0]       r_llen;
    logic [1:0]       r_ocause;
    logic             r_olast;

    logic             ram_we;
    logic             ram_re;
    logic [7:0]       ram_rdata;
    logic             out_free;
    logic             ld;
    logic             ld_valid;
    logic             ld_last;
    logic             acc;

    // Line RAM
    clat_ram #(
        .WIDTH (8),
        .DEPTH (LINE_LEN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_rx_byte),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != clat_pkg::S_IDLE);
    assign acc        = i_in_valid && (r_state == clat_pkg::S_IDLE);
    assign out_free   = !r_ovalid || !i_out_stall;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clat_pkg::S_IDLE;
            r_wp    <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
        end
    end

    // Scan context
    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_cause    <= n_cause;
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_in_tok   <= n_in_tok;
        r_prev_nul <= n_prev_nul;
        r_pstart   <= n_pstart;
        r_plen     <= n_plen;
    end

    // Sequencer: edit the line, then walk it one byte per read
    always_comb begin
        n_state    = r_state;
        n_wp       = r_wp;
        n_len      = r_len;
        n_cause    = r_cause;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_in_tok   = r_in_tok;
        n_prev_nul = r_prev_nul;
        n_pstart   = r_pstart;
        n_plen     = r_plen;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ld         = 1'b0;
        ld_valid   = 1'b0;
        ld_last    = 1'b0;

        case (r_state)
            clat_pkg::S_IDLE: begin
                if (acc) begin
                    n_idx      = '0;
                    n_cnt      = '0;
                    n_in_tok   = 1'b0;
                    n_prev_nul = 1'b0;
                    if (i_rx_byte inside {clat_pkg::CH_CR, clat_pkg::CH_LF}) begin
                        n_len   = r_wp;
                        n_cause = clat_pkg::CAUSE_EOL;
                        n_wp    = '0;
                        n_state = clat_pkg::S_RD;
                    end else if (i_rx_byte == clat_pkg::CH_BS) begin
                        if (r_wp != '0) begin
                            n_wp = r_wp - AW'(1);
                        end
                    end else if (i_rx_byte == clat_pkg::CH_ETX) begin
                        n_len   = '0;
                        n_cause = clat_pkg::CAUSE_CANCEL;
                        n_wp    = '0;
                        n_state = clat_pkg::S_RD;
                    end else if (r_wp < AW'(LINE_LEN - 1)) begin
                        ram_we = 1'b1;
                        n_wp   = r_wp + AW'(1);
                    end else begin
                        n_len   = r_wp;
                        n_cause = clat_pkg::CAUSE_FULL;
                        n_wp    = '0;
                        n_state = clat_pkg::S_RD;
                    end
                end
            end

            clat_pkg::S_RD: begin
                if (r_idx == r_len) begin
                    n_state = clat_pkg::S_FIN;
                end else begin
                    ram_re  = 1'b1;
                    n_state = clat_pkg::S_CHK;
                end
            end

            clat_pkg::S_CHK: begin
                if ((ram_rdata == clat_pkg::CH_NUL) && r_prev_nul) begin
                    // double NUL stops the walk
                    n_state = clat_pkg::S_FIN;
                end else if (clat_pkg::blank_char(ram_rdata)) begin
                    n_prev_nul = (ram_rdata == clat_pkg::CH_NUL);
                    n_in_tok   = 1'b0;
                    n_idx      = r_idx + AW'(1);
                    n_state    = clat_pkg::S_RD;
                end else if (r_in_tok) begin
                    n_prev_nul = 1'b0;
                    n_plen     = r_plen + AW'(1);
                    n_idx      = r_idx + AW'(1);
                    n_state    = clat_pkg::S_RD;
                end else if (r_cnt >= CW'(MAX_TOKENS)) begin
                    n_state = clat_pkg::S_FIN;
                end else if ((r_cnt == '0) || out_free) begin
                    // flush the previous token, open a new one
                    ld         = (r_cnt != '0);
                    ld_valid   = 1'b1;
                    n_pstart   = r_idx;
                    n_plen     = AW'(1);
                    n_cnt      = r_cnt + CW'(1);
                    n_in_tok   = 1'b1;
                    n_prev_nul = 1'b0;
                    n_idx      = r_idx + AW'(1);
                    n_state    = clat_pkg::S_RD;
                end
            end

            clat_pkg::S_FIN: begin
                if (out_free) begin
                    ld       = 1'b1;
                    ld_valid = (r_cnt != '0);
                    ld_last  = 1'b1;
                    n_state  = clat_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = clat_pkg::S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ld) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_tvalid <= ld_valid;
            r_tindex <= ld_valid ? 4'(r_cnt - CW'(1)) : 4'd0;
            r_tstart <= ld_valid ? 6'(r_pstart) : 6'd0;
            r_tlen   <= ld_valid ? 6'(r_plen) : 6'd0;
            r_llen   <= 6'(r_len);
            r_ocause <= r_cause;
            r_olast  <= ld_last;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_token_valid  = r_tvalid;
    assign o_token_index  = r_tindex;
    assign o_token_start  = r_tstart;
    assign o_token_length = r_tlen;
    assign o_line_length  = r_llen;
    assign o_end_cause    = r_ocause;
    assign o_last_token   = r_olast;

endmodule

[hw/rtl/clat_checker.sv]
// Port-level checks for the command line assembler tokenizer, bound to the top level.
module clat_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_token_valid,
    input logic [3:0] o_token_index,
    input logic [5:0] o_token_start,
    input logic [5:0] o_token_length,
    input logic [5:0] o_line_length,
    input logic [1:0] o_end_cause,
    input logic       o_last_token
);

    // Hold a stalled request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_token_start) && $stable(o_token_length) &&
            $stable(o_last_token) && $stable(o_token_index))
        else $error("output payload changed while stalled");

    // Invalid result is the only one of its line and carries zeros
    a_invalid_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_token_valid |->
            o_last_token && (o_token_index == 4'd0) &&
            (o_token_start == 6'd0) && (o_token_length == 6'd0))
        else $error("invalid result with nonzero fields or not last");

    // A result that is not last must be a token
    a_not_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_token |-> o_token_valid)
        else $error("non-final result without token");

    // Cancel always yields an empty line
    a_cancel_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_end_cause == clat_pkg::CAUSE_CANCEL) |->
            (o_line_length == 6'd0) && !o_token_valid)
        else $error("cancelled line reported with content");

endmodule

bind command_line_assembler_tokenizer_unit clat_checker u_clat_checker (.*);
